/* rtl/csrc_pkg.sv */
// csrc_pkg: shared types, defaults and the crc-16/ccitt-false byte step
// for the sealed record checker. No dependencies.
package csrc_pkg;

  localparam int SLOT_BYTES_DEF = 64;
  localparam int SLOT_COUNT_DEF = 32;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  typedef enum logic [2:0] {
    CAUSE_OK        = 3'd0,
    CAUSE_LEAD_ZERO = 3'd1,
    CAUSE_NO_TERM   = 3'd2,
    CAUSE_BAD_CRC   = 3'd3,
    CAUSE_SHORT     = 3'd4
  } cause_t;

  typedef struct packed {
    logic        close;
    logic [4:0]  slot_number;
    logic        record_ok;
    cause_t      cause;
    logic [5:0]  text_length;
  } verdict_t;

  // one byte of crc-16/ccitt-false (poly 0x1021), msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] x;
    x = {8'h00, crc[15:8] ^ b};
    x = x ^ (x >> 4);
    return (crc << 8) ^ (x << 12) ^ (x << 5) ^ x;
  endfunction

endpackage

/* rtl/csrc_slot_tracker.sv */
// csrc_slot_tracker: per-slot running state (crc, position, terminator,
// trailer) and the verdict for the byte that closes a slot. Uses csrc_pkg.
module csrc_slot_tracker #(
  parameter int SLOT_BYTES = csrc_pkg::SLOT_BYTES_DEF,
  parameter int SLOT_COUNT = csrc_pkg::SLOT_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          slot_byte,
  input  logic                slot_end,
  output csrc_pkg::verdict_t  verdict
);

  localparam int PW = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
  localparam int CW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [15:0]   running_crc, running_crc_next;
  logic [PW-1:0] byte_position, byte_position_next;
  logic          terminator_seen, terminator_seen_next;
  logic [1:0]    trailer_bytes_left, trailer_bytes_left_next;
  logic          leading_zero, leading_zero_next;
  logic [5:0]    terminator_position, terminator_position_next;
  logic [CW-1:0] slot_counter, slot_counter_next;

  logic [PW:0]   pos_inc;
  logic          full;
  logic          in_range;
  logic [15:0]   crc_upd;
  csrc_pkg::cause_t cause;

  always_comb begin
    crc_upd = csrc_pkg::crc_byte(running_crc, slot_byte);
    pos_inc = {1'b0, byte_position} + {{PW{1'b0}}, 1'b1};
    full    = (pos_inc == (PW+1)'(SLOT_BYTES));

    leading_zero_next        = leading_zero |
                               ((byte_position == '0) && (slot_byte == 8'h00));
    running_crc_next         = running_crc;
    terminator_seen_next     = terminator_seen;
    terminator_position_next = terminator_position;
    trailer_bytes_left_next  = trailer_bytes_left;

    if (!terminator_seen) begin
      running_crc_next = crc_upd;
      if (slot_byte == 8'h00) begin
        terminator_seen_next     = 1'b1;
        terminator_position_next = 6'(byte_position);
      end
    end else if (trailer_bytes_left != 2'd0) begin
      running_crc_next        = crc_upd;
      trailer_bytes_left_next = trailer_bytes_left - 2'd1;
    end

    in_range = terminator_seen_next &&
               ({1'b0, terminator_position_next} < 7'(SLOT_BYTES - 2));

    if (!full)                          cause = csrc_pkg::CAUSE_SHORT;
    else if (leading_zero_next)         cause = csrc_pkg::CAUSE_LEAD_ZERO;
    else if (!in_range)                 cause = csrc_pkg::CAUSE_NO_TERM;
    else if (running_crc_next != 16'h0) cause = csrc_pkg::CAUSE_BAD_CRC;
    else                                cause = csrc_pkg::CAUSE_OK;

    verdict.close       = take && (slot_end || full);
    verdict.slot_number = 5'(slot_counter);
    verdict.record_ok   = (cause == csrc_pkg::CAUSE_OK);
    verdict.cause       = cause;
    verdict.text_length = in_range ? terminator_position_next : 6'd0;

    byte_position_next = pos_inc[PW-1:0];
    slot_counter_next  = slot_counter;

    // slot closes: clear per-slot state, count the slot
    if (slot_end || full) begin
      running_crc_next         = csrc_pkg::CRC_INIT;
      byte_position_next       = '0;
      terminator_seen_next     = 1'b0;
      trailer_bytes_left_next  = 2'd2;
      leading_zero_next        = 1'b0;
      terminator_position_next = 6'd0;
      slot_counter_next        = (slot_counter == CW'(SLOT_COUNT - 1)) ? '0 :
                                 slot_counter + {{(CW-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc         <= csrc_pkg::CRC_INIT;
      byte_position       <= '0;
      terminator_seen     <= 1'b0;
      trailer_bytes_left  <= 2'd2;
      leading_zero        <= 1'b0;
      terminator_position <= 6'd0;
      slot_counter        <= '0;
    end else if (take) begin
      running_crc         <= running_crc_next;
      byte_position       <= byte_position_next;
      terminator_seen     <= terminator_seen_next;
      trailer_bytes_left  <= trailer_bytes_left_next;
      leading_zero        <= leading_zero_next;
      terminator_position <= terminator_position_next;
      slot_counter        <= slot_counter_next;
    end
  end

endmodule

/* rtl/crc_sealed_record_check_core.sv */
// crc_sealed_record_check_core: byte-stream slot checker with a result register.
// Depends on csrc_pkg and csrc_slot_tracker.
// the result of a slot is valid in the cycle after its closing byte is accepted
// throughput: one byte per cycle while in_ready is high, set by the combinational crc byte update
// in_ready stays high while the result register is empty or being drained
// reset: crc to 0xFFFF, trailer count to 2, other slot state and slot counter to zero, no result pending
module crc_sealed_record_check_core #(
  parameter int SLOT_BYTES = csrc_pkg::SLOT_BYTES_DEF,
  parameter int SLOT_COUNT = csrc_pkg::SLOT_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] slot_byte,
  input  logic       slot_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] slot_number,
  output logic       record_ok,
  output logic [2:0] fail_cause,
  output logic [5:0] text_length
);

  csrc_pkg::verdict_t verdict;
  logic               take;
  logic               out_valid_next;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  csrc_slot_tracker #(
    .SLOT_BYTES(SLOT_BYTES),
    .SLOT_COUNT(SLOT_COUNT)
  ) u_tracker (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .slot_byte(slot_byte),
    .slot_end (slot_end),
    .verdict  (verdict)
  );

  always_comb begin
    if (verdict.close)  out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else                out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (verdict.close) begin
      slot_number <= verdict.slot_number;
      record_ok   <= verdict.record_ok;
      fail_cause  <= verdict.cause;
      text_length <= verdict.text_length;
    end
  end

`ifndef SYNTHESIS
  a_ok_matches_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (record_ok == (fail_cause == csrc_pkg::CAUSE_OK)))
    else $error("record_ok disagrees with fail_cause");

  a_ok_has_text: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_ok |-> (text_length != 6'd0))
    else $error("valid record with empty text");

  a_no_term_no_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && (fail_cause == csrc_pkg::CAUSE_NO_TERM) |-> (text_length == 6'd0))
    else $error("text length reported without terminator in range");

  a_cause_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fail_cause <= csrc_pkg::CAUSE_SHORT))
    else $error("fail_cause out of range");

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && slot_end |=> out_valid)
    else $error("closing byte produced no result");
`endif

endmodule
